// ===== hdl/uyvy_pkg.sv =====
// Shared types, fixed-point coefficients and channel helpers for the UYVY to RGB24 converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package uyvy_pkg;

  // Q16 channel sums stay within +/- 2^26
  localparam int SUM_W = 27;

  localparam logic signed [SUM_W-1:0] COEF_R  = SUM_W'(89831);
  localparam logic signed [SUM_W-1:0] COEF_GV = SUM_W'(45744);
  localparam logic signed [SUM_W-1:0] COEF_GU = SUM_W'(22127);
  localparam logic signed [SUM_W-1:0] COEF_B  = SUM_W'(113538);

  localparam logic [7:0] CHAN_MAX  = 8'd255;
  localparam logic [7:0] SCALE_NUM = 8'd220;

  typedef struct packed {
    logic [7:0] cb_byte;
    logic [7:0] luma_first;
    logic [7:0] cr_byte;
    logic [7:0] luma_second;
    logic       frame_end_in;
  } in_t;

  typedef struct packed {
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
    logic       frame_end_out;
  } out_t;

  // chroma contributions shared by both pixels of a macropixel
  typedef struct packed {
    logic signed [SUM_W-1:0] r_term;
    logic signed [SUM_W-1:0] g_term;
    logic signed [SUM_W-1:0] b_term;
  } chroma_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // truncate a non-negative Q16 sum and clamp to 0..255
  function automatic logic [7:0] clamp_chan(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-17:0] whole;
    begin
      whole = s[SUM_W-1:16];
      if (s[SUM_W-1]) begin
        clamp_chan = 8'd0;
      end else if (whole > {{(SUM_W-24){1'b0}}, CHAN_MAX}) begin
        clamp_chan = CHAN_MAX;
      end else begin
        clamp_chan = whole[7:0];
      end
    end
  endfunction

  // floor(v * 220 / 256)
  function automatic logic [7:0] scale_chan(input logic [7:0] v);
    logic [15:0] prod;
    begin
      prod = 16'(v) * 16'(SCALE_NUM);
      scale_chan = prod[15:8];
    end
  endfunction

endpackage

// ===== hdl/uyvy_chroma.sv =====
// Chroma stage: forms the registered Q16 chroma terms shared by both pixel lanes.
// Depends on uyvy_pkg.
`timescale 1ns / 1ps
module uyvy_chroma import uyvy_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    valid,
  input  in_t     item,
  output logic    term_valid,
  output chroma_t terms,
  output logic [7:0] luma_first,
  output logic [7:0] luma_second,
  output logic    frame_end
);

  logic signed [7:0]       du;
  logic signed [7:0]       dv;
  logic signed [SUM_W-1:0] du_ext;
  logic signed [SUM_W-1:0] dv_ext;
  chroma_t                 terms_next;

  // byte - 128 in two's complement is the byte with its top bit flipped
  assign du = {~item.cb_byte[7], item.cb_byte[6:0]};
  assign dv = {~item.cr_byte[7], item.cr_byte[6:0]};
  assign du_ext = SUM_W'(du);
  assign dv_ext = SUM_W'(dv);

  always_comb begin
    terms_next.r_term = dv_ext * COEF_R;
    terms_next.g_term = -(dv_ext * COEF_GV) - (du_ext * COEF_GU);
    terms_next.b_term = du_ext * COEF_B;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      term_valid <= 1'b0;
    end else begin
      term_valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    terms       <= terms_next;
    luma_first  <= item.luma_first;
    luma_second <= item.luma_second;
    frame_end   <= item.frame_end_in;
  end

endmodule

// ===== hdl/uyvy_lane.sv =====
// Pixel lane: adds luma to the shared chroma terms, truncates and clamps each channel.
// Depends on uyvy_pkg.
`timescale 1ns / 1ps
module uyvy_lane import uyvy_pkg::*; (
  input  logic       clk,
  input  logic [7:0] luma,
  input  chroma_t    terms,
  output rgb_t       pixel
);

  logic signed [SUM_W-1:0] base;
  rgb_t                    pixel_next;

  assign base = {{(SUM_W-24){1'b0}}, luma, 16'd0};

  always_comb begin
    pixel_next.r = clamp_chan(base + terms.r_term);
    pixel_next.g = clamp_chan(base + terms.g_term);
    pixel_next.b = clamp_chan(base + terms.b_term);
  end

  always_ff @(posedge clk) begin
    pixel <= pixel_next;
  end

endmodule

// ===== hdl/uyvy_to_rgb24_converter.sv =====
// UYVY to RGB24 converter top level: chroma stage, two pixel lanes and the output merge.
// Depends on uyvy_pkg, uyvy_chroma and uyvy_lane.
// A transaction accepted by start passes the three register stages (chroma products, lane
// clamp, scale) and then appears on result with done high.
// Throughput: one macropixel per clock; busy is always low since the receiver cannot stall.
// Reset clears the stage valid flags only, so transactions in flight are dropped; none is invented.
`timescale 1ns / 1ps
module uyvy_to_rgb24_converter import uyvy_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  in_t  in_item,
  output logic busy,
  output logic done,
  output out_t result
);

  logic       accept;
  logic       term_valid;
  chroma_t    terms;
  logic [7:0] luma_first;
  logic [7:0] luma_second;
  logic       frame_end_s1;
  logic       lane_valid;
  logic       frame_end_s2;
  rgb_t       pixel_first;
  rgb_t       pixel_second;
  out_t       result_next;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  uyvy_chroma u_chroma (
    .clk         (clk),
    .rst         (rst),
    .valid       (accept),
    .item        (in_item),
    .term_valid  (term_valid),
    .terms       (terms),
    .luma_first  (luma_first),
    .luma_second (luma_second),
    .frame_end   (frame_end_s1)
  );

  uyvy_lane u_lane_first (
    .clk   (clk),
    .luma  (luma_first),
    .terms (terms),
    .pixel (pixel_first)
  );

  uyvy_lane u_lane_second (
    .clk   (clk),
    .luma  (luma_second),
    .terms (terms),
    .pixel (pixel_second)
  );

  // merge both lanes into one result transaction, scaling each channel by 220/256
  always_comb begin
    result_next.red_first     = scale_chan(pixel_first.r);
    result_next.green_first   = scale_chan(pixel_first.g);
    result_next.blue_first    = scale_chan(pixel_first.b);
    result_next.red_second    = scale_chan(pixel_second.r);
    result_next.green_second  = scale_chan(pixel_second.g);
    result_next.blue_second   = scale_chan(pixel_second.b);
    result_next.frame_end_out = frame_end_s2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      lane_valid <= term_valid;
      done       <= lane_valid;
    end
  end

  always_ff @(posedge clk) begin
    frame_end_s2 <= frame_end_s1;
    result       <= result_next;
  end

endmodule

// ===== dv/uyvy_to_rgb24_converter_test.sv =====
// Self-checking testbench for the UYVY to RGB24 converter: directed corner groups, then random
// frames under several sender idle patterns. Depends on uyvy_pkg and uyvy_to_rgb24_converter.
`timescale 1ns / 1ps
module uyvy_to_rgb24_converter_test;
  import uyvy_pkg::*;

  // Q16 color coefficients, kept apart from the design's own copies
  localparam int K_RED      = 89831;
  localparam int K_GREEN_CR = 45744;
  localparam int K_GREEN_CB = 22127;
  localparam int K_BLUE     = 113538;
  localparam int CHROMA_ZERO = 128;
  localparam int STALL_LIMIT = 1000;

  logic clk;
  logic rst;
  logic start;
  in_t  in_item;
  logic busy;
  logic done;
  out_t result;

  out_t pending_pixels[$];
  int   mismatch_count;
  int   groups_sent;
  int   pixels_checked;
  int   frame_ends_seen;
  int   quiet_cycles;
  int   idle_pct;

  uyvy_to_rgb24_converter uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .in_item(in_item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always #4 clk = ~clk;

  // truncate toward zero, clamp to 0..255, scale by 220/256
  function automatic logic [7:0] clip_scale(int q16);
    int whole;
    if (q16 < 0) return 8'd0;
    whole = q16 >>> 16;
    if (whole > 255) whole = 255;
    return 8'((whole * 220) >> 8);
  endfunction

  function automatic out_t rgb_from_uyvy(in_t grp);
    out_t px;
    int   dcb;
    int   dcr;
    int   base0;
    int   base1;
    dcb   = int'(grp.cb_byte) - CHROMA_ZERO;
    dcr   = int'(grp.cr_byte) - CHROMA_ZERO;
    base0 = int'(grp.luma_first) * 65536;
    base1 = int'(grp.luma_second) * 65536;
    px.red_first     = clip_scale(base0 + K_RED * dcr);
    px.green_first   = clip_scale(base0 - K_GREEN_CR * dcr - K_GREEN_CB * dcb);
    px.blue_first    = clip_scale(base0 + K_BLUE * dcb);
    px.red_second    = clip_scale(base1 + K_RED * dcr);
    px.green_second  = clip_scale(base1 - K_GREEN_CR * dcr - K_GREEN_CB * dcb);
    px.blue_second   = clip_scale(base1 + K_BLUE * dcb);
    px.frame_end_out = grp.frame_end_in;
    return px;
  endfunction

  function automatic in_t make_group(logic [7:0] cb, logic [7:0] y0, logic [7:0] cr,
                                     logic [7:0] y1, logic fe);
    in_t grp;
    grp.cb_byte      = cb;
    grp.luma_first   = y0;
    grp.cr_byte      = cr;
    grp.luma_second  = y1;
    grp.frame_end_in = fe;
    return grp;
  endfunction

  // favor the rails and the chroma midpoint, otherwise uniform
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'(CHROMA_ZERO - 3 + $urandom_range(0, 6));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // send one transaction; start stays high so back-to-back calls stream
  task automatic send_group(in_t grp);
    // before each idle cycle draw afresh whether to hold start low, so on average idle_pct percent of cycles are idle
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= grp;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic test_extremes();
    send_group(make_group(8'd0,   8'd0,   8'd0,   8'd0,   1'b0));
    send_group(make_group(8'd255, 8'd255, 8'd255, 8'd255, 1'b0));
    send_group(make_group(8'd128, 8'd0,   8'd128, 8'd255, 1'b0));
    send_group(make_group(8'd128, 8'd255, 8'd128, 8'd0,   1'b0));
    send_group(make_group(8'd0,   8'd255, 8'd255, 8'd0,   1'b0));
    send_group(make_group(8'd255, 8'd0,   8'd0,   8'd255, 1'b0));
    send_group(make_group(8'd170, 8'd85,  8'd85,  8'd170, 1'b0));
  endtask

  task automatic test_clamp_cases();
    // negative sums on red and blue
    send_group(make_group(8'd0,   8'd10,  8'd0,   8'd20,  1'b0));
    // green lands just below zero, truncation must still give zero
    send_group(make_group(8'd129, 8'd0,   8'd128, 8'd0,   1'b0));
    send_group(make_group(8'd128, 8'd0,   8'd129, 8'd1,   1'b0));
    // overflow on red and blue
    send_group(make_group(8'd255, 8'd240, 8'd255, 8'd200, 1'b0));
    // overflow on green from low chroma
    send_group(make_group(8'd0,   8'd250, 8'd0,   8'd180, 1'b0));
    // near the 255 boundary with neutral chroma
    send_group(make_group(8'd128, 8'd254, 8'd128, 8'd1,   1'b0));
  endtask

  task automatic test_frame_marker();
    send_group(make_group(8'd64,  8'd32,  8'd192, 8'd96,  1'b1));
    send_group(make_group(8'd200, 8'd16,  8'd50,  8'd235, 1'b0));
    send_group(make_group(8'd90,  8'd128, 8'd160, 8'd64,  1'b1));
    send_group(make_group(8'd255, 8'd255, 8'd0,   8'd0,   1'b1));
  endtask

  // frames of random length, frame end on the last group, with a little marker noise
  task automatic test_random_frames(int count, int pct);
    int sent;
    int len;
    logic fe;
    sent = 0;
    idle_pct = pct;
    while (sent < count) begin
      len = $urandom_range(1, 32);
      for (int i = 0; i < len && sent < count; i++) begin
        fe = (i == len - 1);
        if ($urandom_range(0, 19) == 0) fe = ~fe;
        send_group(make_group(pick_byte(), pick_byte(), pick_byte(), pick_byte(), fe));
        sent++;
      end
    end
    idle_pct = 0;
  endtask

  task automatic test_pause_until_drained();
    wait_drained();
    send_group(make_group(8'd12, 8'd34, 8'd56, 8'd78, 1'b1));
  endtask

  // record each accepted transaction and check each result in order
  always @(posedge clk) begin : scoreboard
    out_t exp_px;
    if (!rst) begin
      if (start && !busy) begin
        pending_pixels.push_back(rgb_from_uyvy(in_item));
        groups_sent++;
      end
      if (done) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, result);
          mismatch_count++;
        end else begin
          exp_px = pending_pixels.pop_front();
          check_field("red_first",     exp_px.red_first,     result.red_first);
          check_field("green_first",   exp_px.green_first,   result.green_first);
          check_field("blue_first",    exp_px.blue_first,    result.blue_first);
          check_field("red_second",    exp_px.red_second,    result.red_second);
          check_field("green_second",  exp_px.green_second,  result.green_second);
          check_field("blue_second",   exp_px.blue_second,   result.blue_second);
          check_field("frame_end_out", 8'(exp_px.frame_end_out), 8'(result.frame_end_out));
          pixels_checked++;
          if (result.frame_end_out) frame_ends_seen++;
        end
      end
    end
  end

  // end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk             = 1'b0;
    mismatch_count  = 0;
    groups_sent     = 0;
    pixels_checked  = 0;
    frame_ends_seen = 0;
    quiet_cycles    = 0;
    idle_pct        = 0;
    rst     <= 1'b1;
    start   <= 1'b0;
    in_item <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_clamp_cases();
    test_frame_marker();
    test_random_frames(480, 0);
    test_pause_until_drained();
    test_random_frames(480, 58);
    // results cannot be held off, so the combined phase idles the sender only
    test_random_frames(490, 33);

    wait_drained();
    repeat (10) @(posedge clk);

    $display("Sent %0d macropixels, checked %0d results with %0d frame ends,",
             groups_sent, pixels_checked, frame_ends_seen);
    $display("covering rail, clamp and midpoint chroma cases under streaming and idle gaps.");
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
